### rtl/euclidean_top_k_nearest_defines.svh
// Assertion macros shared by the checker of the top-k nearest block.
`ifndef EUCLIDEAN_TOP_K_NEAREST_DEFINES_SVH
`define EUCLIDEAN_TOP_K_NEAREST_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define ETKN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ETKN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/etkn_pkg.sv
// Shared constants and types of the top-k nearest neighbor block.
`default_nettype none
package etkn_pkg;

    localparam int KEEP_COUNT = 10;
    localparam int INDEX_BITS = 16;

    localparam int KIDX_W     = (INDEX_BITS < 16) ? INDEX_BITS : 16;
    localparam int SUM_W      = 44;
    localparam int SQ_W       = 32;
    localparam int ROOT_W     = 22;
    localparam int STEP_W     = $clog2(ROOT_W);
    localparam int CNT_W      = $clog2(KEEP_COUNT + 1);
    localparam int CELL_W     = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 40;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef logic [CNT_W-1:0] t_cnt;

    // One kept neighbor: squared distance and candidate index.
    typedef struct packed {
        logic [SUM_W-1:0]  sq_dist;
        logic [KIDX_W-1:0] idx;
    } t_entry;

    // Per-cell control from the list controller.
    typedef struct packed {
        logic insert;
        logic occupied;
        logic free_head;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_ACCEPT,
        ST_WAIT,
        ST_DRAIN,
        ST_ROOT
    } t_state;

endpackage
`default_nettype wire

### rtl/etkn_cell.sv
// One cell of the sorted keep list: compares against the offered entry and shifts.
`default_nettype none
module etkn_cell
    import etkn_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_entry    i_new,
    input  wire t_entry    i_left,
    input  wire logic      i_left_gt,
    output t_entry         o_entry,
    output logic           o_gt
);

    t_entry r_entry;

    // Rank above the offered entry: larger distance, or equal and smaller index
    assign o_gt = i_ctl.occupied &&
                  ((r_entry.sq_dist > i_new.sq_dist) ||
                   ((r_entry.sq_dist == i_new.sq_dist) && (r_entry.idx < i_new.idx)));

    assign o_entry = r_entry;

    // Shift up from the neighbor or take the offered entry at the insertion point
    always_ff @(posedge i_clk) begin
        if (i_ctl.insert && (o_gt || i_ctl.free_head)) begin
            r_entry <= i_left_gt ? i_left : i_new;
        end
    end

endmodule
`default_nettype wire

### rtl/etkn_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
`default_nettype none
module etkn_sqrt
    import etkn_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SUM_W-1:0]  i_value,
    output logic                   o_done,
    output logic [ROOT_W-1:0]      o_root
);

    localparam int REM_W = ROOT_W + 2;

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [SUM_W-1:0]    r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;

    logic [REM_W+1:0]    w_cat;
    logic [REM_W+1:0]    w_trial;
    logic                w_fit;
    logic [REM_W+1:0]    w_diff;

    // Trial subtraction of one root bit
    assign w_cat   = {r_rem, r_rad[SUM_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_fit   = (w_cat >= w_trial);
    assign w_diff  = w_cat - w_trial;

    // Control: run ROOT_W steps after start, then hold the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(ROOT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: load the radicand, then advance one digit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[SUM_W-3:0], 2'b00};
            r_rem  <= w_fit ? w_diff[REM_W-1:0] : w_cat[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

### rtl/euclidean_top_k_nearest.sv
// Top level of the top-k nearest neighbor block by Euclidean distance.
// Components enter one per cycle while ready; a candidate's sum then enters the keep list.
// A final candidate stops intake until all kept entries are sent, largest distance first.
// After the final candidate, each result waits on its own 22-step square root.
// Synchronous active-low reset clears the running sum, the kept count and all handshakes.
`default_nettype none
module euclidean_top_k_nearest
    import etkn_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // query_index[15:0], candidate_index[31:16],
    // query_component[47:32], candidate_component[63:48]
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  wire logic                  i_s_axis_tlast,   // last_component
    input  wire logic                  i_s_axis_tuser,   // last_candidate
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // neighbor_index[15:0], distance[37:16], zero[39:38]
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    output logic                       o_m_axis_tlast    // last
);

    t_state r_state;
    t_state n_state;

    // Input fields
    logic [15:0]        w_qidx;
    logic [15:0]        w_cidx;
    logic [15:0]        w_qc;
    logic [15:0]        w_cc;
    logic               w_in_acc;
    logic               w_self;
    logic signed [16:0] w_diff;

    assign w_qidx   = i_s_axis_tdata[15:0];
    assign w_cidx   = i_s_axis_tdata[31:16];
    assign w_qc     = i_s_axis_tdata[47:32];
    assign w_cc     = i_s_axis_tdata[63:48];
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_self   = (w_qidx[KIDX_W-1:0] == w_cidx[KIDX_W-1:0]);
    assign w_diff   = $signed({w_qc[15], w_qc}) - $signed({w_cc[15], w_cc});

    // Stage 1: difference
    logic               r_s1_valid;
    logic signed [16:0] r_s1_diff;
    logic               r_s1_self;
    logic               r_s1_lcomp;
    logic               r_s1_lcand;
    logic [KIDX_W-1:0]  r_s1_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_diff  <= w_self ? 17'sd0 : w_diff;
            r_s1_self  <= w_self;
            r_s1_lcomp <= i_s_axis_tlast;
            r_s1_lcand <= i_s_axis_tuser;
            r_s1_idx   <= w_cidx[KIDX_W-1:0];
        end
    end

    // Stage 2: square
    logic signed [33:0] w_prod;
    logic               r_s2_valid;
    logic [SQ_W-1:0]    r_s2_sq;
    logic               r_s2_self;
    logic               r_s2_lcomp;
    logic               r_s2_lcand;
    logic [KIDX_W-1:0]  r_s2_idx;

    assign w_prod = r_s1_diff * r_s1_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_sq    <= w_prod[SQ_W-1:0];
            r_s2_self  <= r_s1_self;
            r_s2_lcomp <= r_s1_lcomp;
            r_s2_lcand <= r_s1_lcand;
            r_s2_idx   <= r_s1_idx;
        end
    end

    // Stage 3: saturating accumulate, offer a non-self candidate on its last component
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W:0]   w_sum_wide;
    logic [SUM_W-1:0] w_sum_sat;
    logic             r_ofr_valid;
    logic             r_ofr_trig;
    t_entry           r_ofr;

    assign w_sum_wide = {1'b0, r_sum} + (SUM_W + 1)'(r_s2_sq);
    assign w_sum_sat  = w_sum_wide[SUM_W] ? SUM_MAX : w_sum_wide[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_ofr_valid <= 1'b0;
            r_ofr_trig  <= 1'b0;
        end else begin
            r_ofr_valid <= r_s2_valid && r_s2_lcomp && !r_s2_self;
            r_ofr_trig  <= r_s2_valid && r_s2_lcomp && r_s2_lcand;
            if (r_s2_valid) begin
                r_sum <= r_s2_lcomp ? '0 : w_sum_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_ofr.sq_dist <= w_sum_sat;
            r_ofr.idx     <= r_s2_idx;
        end
    end

    // Keep list: chain of sorted cells, highest rank at the top occupied cell
    t_cnt   r_count;
    t_entry w_cell [KEEP_COUNT];
    logic   w_gt   [KEEP_COUNT];
    logic   w_full;
    logic   w_insert;

    assign w_full   = (r_count == CNT_W'(KEEP_COUNT));
    assign w_insert = r_ofr_valid &&
                      (!w_full || (r_ofr.sq_dist < w_cell[KEEP_COUNT-1].sq_dist));

    for (genvar g = 0; g < KEEP_COUNT; g++) begin : g_cell
        t_cell_ctl w_ctl;
        t_entry    w_left;
        logic      w_left_gt;

        assign w_ctl.insert    = w_insert;
        assign w_ctl.occupied  = (CNT_W'(g) < r_count);
        assign w_ctl.free_head = (CNT_W'(g) == r_count);

        if (g == 0) begin : g_first
            assign w_left    = r_ofr;
            assign w_left_gt = 1'b0;
        end else begin : g_rest
            assign w_left    = w_cell[g-1];
            assign w_left_gt = w_gt[g-1];
        end

        etkn_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_new     (r_ofr),
            .i_left    (w_left),
            .i_left_gt (w_left_gt),
            .o_entry   (w_cell[g]),
            .o_gt      (w_gt[g])
        );
    end

    // Drain read: top occupied cell
    t_cnt   w_rd;
    t_entry w_top;

    assign w_rd  = r_count - CNT_W'(1);
    assign w_top = w_cell[w_rd[CELL_W-1:0]];

    // Square root unit
    logic              w_root_start;
    logic              w_root_done;
    logic [ROOT_W-1:0] w_root;

    etkn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value (w_top.sq_dist),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACCEPT: begin
                if (w_in_acc && i_s_axis_tlast && i_s_axis_tuser) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (r_ofr_trig) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = (r_count == '0) ? ST_ACCEPT : ST_ROOT;
            end
            ST_ROOT: begin
                if (w_root_done && (!o_m_axis_tvalid || i_m_axis_tready)) begin
                    n_state = ST_DRAIN;
                end
            end
            default: begin
                n_state = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

    // State outputs
    logic w_out_load;

    always_comb begin
        o_s_axis_tready = 1'b0;
        w_root_start    = 1'b0;
        w_out_load      = 1'b0;
        case (r_state)
            ST_ACCEPT: begin
                o_s_axis_tready = 1'b1;
            end
            ST_WAIT: begin
                o_s_axis_tready = 1'b0;
            end
            ST_DRAIN: begin
                w_root_start = (r_count != '0);
            end
            ST_ROOT: begin
                w_out_load = w_root_done && (!o_m_axis_tvalid || i_m_axis_tready);
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    // Kept count: grow on insert below full, shrink per result sent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_insert && !w_full) begin
            r_count <= r_count + CNT_W'(1);
        end else if (w_out_load) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // Hold the index and last flag of the entry under root extraction
    logic [KIDX_W-1:0] r_root_idx;
    logic              r_root_last;

    always_ff @(posedge i_clk) begin
        if (w_root_start) begin
            r_root_idx  <= w_top.idx;
            r_root_last <= (r_count == CNT_W'(1));
        end
    end

    // Output register
    logic              r_out_valid;
    logic [15:0]       r_out_idx;
    logic [ROOT_W-1:0] r_out_dist;
    logic              r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_idx  <= 16'(r_root_idx);
            r_out_dist <= w_root;
            r_out_last <= r_root_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_dist, r_out_idx};
    assign o_m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

### rtl/etkn_chk.sv
// Port-level checker of the top-k nearest block, bound to the top level.
`default_nettype none
`include "euclidean_top_k_nearest_defines.svh"
module etkn_chk
    import etkn_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input wire logic                  i_s_axis_tlast,
    input wire logic                  i_s_axis_tuser,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire logic                  o_m_axis_tlast
);

    // A stalled result transaction holds its payload
    `ETKN_ASSERT(a_out_hold,
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast),
        "result changed while stalled")

    // No result right after reset
    `ETKN_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

    // A final-candidate transaction stops intake
    `ETKN_ASSERT(a_trig_stall,
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast && i_s_axis_tuser |=>
            !o_s_axis_tready,
        "intake kept open after final candidate")

    // Intake stays closed while a run still has results to send
    `ETKN_ASSERT(a_run_closed,
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready,
        "intake open in the middle of a run")

endmodule

bind euclidean_top_k_nearest etkn_chk u_etkn_chk (.*);
`default_nettype wire
